// File: hdl/bfdp_pkg.sv
// ----------------------------------------------------------------------------
// bfdp_pkg
// Shared types and constants for the bounded FIFO with overflow policy.
// ----------------------------------------------------------------------------
package bfdp_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Fixed field widths of the channels
   localparam int OPCODE_W     = 2;
   localparam int WORD_W       = 32;
   localparam int FILL_W       = 5;
   localparam int POLICY_W     = 2;
   localparam int CAP_FIELD_W  = 5;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 5;
   localparam int RSP_TDATA_W  = 40;
   localparam int RSP_TUSER_W  = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_PULL  = 2'd1,
      OP_CLOSE = 2'd2
   } opcode_type;

   typedef enum logic [POLICY_W-1:0] {
      POLICY_BLOCK       = 2'd0,
      POLICY_DROP_OLDEST = 2'd1,
      POLICY_DROP_NEWEST = 2'd2
   } policy_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DROP_POLICY = 1'd0,
      CSR_CAPACITY    = 1'd1
   } csr_index_type;

   // Per-cell control from the queue controller
   typedef struct packed {
      logic shift;   // take the word of the next cell up
      logic load;    // take the incoming push word
   } cell_ctl_type;

endpackage

// File: hdl/bfdp_cell.sv
// ----------------------------------------------------------------------------
// bfdp_cell
// One storage cell of the shifting queue: loads a pushed word or takes the
// word of its upper neighbor when the queue advances.
// ----------------------------------------------------------------------------
module bfdp_cell #(
   parameter int DATA_WIDTH = bfdp_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  bfdp_pkg::cell_ctl_type ctl,
   input  logic [DATA_WIDTH-1:0] load_data,
   input  logic [DATA_WIDTH-1:0] next_data,
   output logic [DATA_WIDTH-1:0] data
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// File: hdl/bounded_fifo_with_drop_policy_core.sv
// ----------------------------------------------------------------------------
// bounded_fifo_with_drop_policy_core
// Bounded FIFO with programmable capacity and block / drop-oldest /
// drop-newest overflow handling, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Response: registered, appearing in the cycle after its request beat is taken.
// Throughput: one request per cycle while the response side takes beats; every
//   operation finishes in the single update of the cell row and the count register.
// Reset (synchronous, active high): queue empty and open, policy block,
//   capacity DEPTH, no response pending. Cell contents are not cleared.
module bounded_fifo_with_drop_policy_core #(
   parameter int DEPTH      = bfdp_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = bfdp_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,

   // Request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bfdp_pkg::WORD_W-1:0]         req_tdata,  // [31:0] push_data
   input  logic [bfdp_pkg::OPCODE_W-1:0]       req_tuser,  // [1:0] opcode

   // Response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] accepted, [1] dropped, [6:2] fill_level, [38:7] pull_data, [39] zero
   output logic [bfdp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // [0] pull_valid, [1] end_of_stream
   output logic [bfdp_pkg::RSP_TUSER_W-1:0]    rsp_tuser,

   // Register write port
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bfdp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bfdp_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   // Width wide enough for both the count and the 5-bit capacity field
   localparam int CAP_W = (CNT_W > bfdp_pkg::CAP_FIELD_W) ? CNT_W : bfdp_pkg::CAP_FIELD_W;
   localparam int EXT_W = 64;

   // ------------------------------------------------------------------
   // Configuration registers; the user, not the block, must see that writes only arrive while the queue is idle
   // ------------------------------------------------------------------
   bfdp_pkg::policy_type policy_ff, policy_in;
   logic [CAP_W-1:0]     cap_ff, cap_in;

   assign csr_ready = 1'b1;

   always_comb begin
      policy_in = policy_ff;
      cap_in    = cap_ff;
      if (csr_valid) begin
         case (bfdp_pkg::csr_index_type'(csr_index))
            bfdp_pkg::CSR_DROP_POLICY:
               policy_in = bfdp_pkg::policy_type'(csr_data[bfdp_pkg::POLICY_W-1:0]);
            bfdp_pkg::CSR_CAPACITY:
               cap_in = CAP_W'(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= bfdp_pkg::POLICY_BLOCK;
         cap_ff    <= CAP_W'(DEPTH);
      end else begin
         policy_ff <= policy_in;
         cap_ff    <= cap_in;
      end
   end

   // Clamp the programmed capacity into 1..DEPTH
   logic [CAP_W-1:0] eff_cap;
   always_comb begin
      eff_cap = cap_ff;
      if (cap_ff == '0) begin
         eff_cap = CAP_W'(1);
      end else if (cap_ff > CAP_W'(DEPTH)) begin
         eff_cap = CAP_W'(DEPTH);
      end
   end

   // ------------------------------------------------------------------
   // Handshake: advance when the response register is free or draining
   // ------------------------------------------------------------------
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign advance    = req_tvalid && req_tready;

   // ------------------------------------------------------------------
   // Queue control: count, closed flag and per-cell commands
   // ------------------------------------------------------------------
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  closed_ff, closed_in;
   logic                  full;
   logic                  do_shift, do_load;
   logic [CNT_W-1:0]      wr_pos;
   logic                  acc, drp, pvalid, eos;
   logic [DATA_WIDTH-1:0] head_data;
   logic [DATA_WIDTH-1:0] push_word;
   logic [EXT_W-1:0]      push_ext;
   logic [EXT_W-1:0]      head_ext;

   assign full      = CAP_W'(count_ff) >= eff_cap;
   assign push_ext  = EXT_W'(req_tdata);
   assign push_word = push_ext[DATA_WIDTH-1:0];
   assign head_ext  = EXT_W'(head_data);

   always_comb begin
      count_in  = count_ff;
      closed_in = closed_ff;
      do_shift  = 1'b0;
      do_load   = 1'b0;
      wr_pos    = count_ff;
      acc       = 1'b0;
      drp       = 1'b0;
      pvalid    = 1'b0;
      eos       = 1'b0;
      case (bfdp_pkg::opcode_type'(req_tuser))
         bfdp_pkg::OP_PUSH: begin
            // a closed queue refuses every push
            if (!closed_ff) begin
               if (!full) begin
                  do_load  = 1'b1;
                  acc      = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else if (policy_ff == bfdp_pkg::POLICY_DROP_OLDEST) begin
                  // evict head: shift the row and write one slot lower
                  do_shift = 1'b1;
                  do_load  = 1'b1;
                  wr_pos   = count_ff - CNT_W'(1);
                  acc      = 1'b1;
                  drp      = 1'b1;
               end else if (policy_ff == bfdp_pkg::POLICY_DROP_NEWEST) begin
                  acc = 1'b1;
                  drp = 1'b1;
               end
            end
         end
         bfdp_pkg::OP_PULL: begin
            if (count_ff != '0) begin
               do_shift = 1'b1;
               pvalid   = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end else if (closed_ff) begin
               eos = 1'b1;
            end
         end
         bfdp_pkg::OP_CLOSE: begin
            closed_in = 1'b1;
         end
         default: ;
      endcase
      // hold everything unless a request beat is taken
      if (!advance) begin
         count_in  = count_ff;
         closed_in = closed_ff;
         do_shift  = 1'b0;
         do_load   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         closed_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         closed_ff <= closed_in;
      end
   end

   // ------------------------------------------------------------------
   // Cell row: cell 0 is the head, the tail sits at cell count-1
   // ------------------------------------------------------------------
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      bfdp_pkg::cell_ctl_type ctl;
      logic [DATA_WIDTH-1:0]  upper;
      logic [CNT_W-1:0]       pos;

      assign pos = CNT_W'(i);
      assign ctl = '{shift: do_shift, load: do_load && (wr_pos == pos)};

      if (i == DEPTH - 1) begin : g_top
         assign upper = '0;
      end else begin : g_mid
         assign upper = cell_data[i+1];
      end

      bfdp_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .load_data(push_word),
         .next_data(upper),
         .data     (cell_data[i])
      );
   end

   assign head_data = cell_data[0];

   // ------------------------------------------------------------------
   // Response register
   // ------------------------------------------------------------------
   logic [bfdp_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [bfdp_pkg::RSP_TUSER_W-1:0] rsp_user_ff, rsp_user_in;
   logic [CAP_W-1:0]                 fill_ext;
   logic [bfdp_pkg::WORD_W-1:0]      pull_word;

   assign fill_ext  = CAP_W'(count_in);
   assign pull_word = pvalid ? head_ext[bfdp_pkg::WORD_W-1:0] : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, pull_word, fill_ext[bfdp_pkg::FILL_W-1:0], drp, acc};
         rsp_user_in  = {eos, pvalid};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_beat_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_count_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(count_ff))
      else $error("fill count moved without a request");

   a_closed_sticks: assert property (@(posedge clock) disable iff (reset)
      closed_ff |=> closed_ff)
      else $error("closed queue reopened");

   a_pull_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_user_ff[0] && rsp_user_ff[1]))
      else $error("pull data and end of stream together");
`endif

endmodule

// File: bench/tb_bounded_fifo_with_drop_policy_core.sv
// ----------------------------------------------------------------------------
// tb_bounded_fifo_with_drop_policy_core
// Self-checking bench for the bounded FIFO with block / drop-oldest /
// drop-newest overflow handling. A shadow queue predicts every response.
// The bench drives a directed opening, then random push / pull traffic under
// a spread of policies and capacities, and ends with close and drain.
// ----------------------------------------------------------------------------
module tb_bounded_fifo_with_drop_policy_core;
   timeunit 1ns;
   timeprecision 1ps;

   import bfdp_pkg::*;

   localparam int DEPTH          = DEPTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 2000;

   // Opcode three has no name in the package: the block treats it as a no-op
   localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;
   // Policy code three is outside the enum and must behave as block
   localparam logic [POLICY_W-1:0] POLICY_SPARE = 2'd3;

   // One predicted response beat, field by field
   typedef struct {
      logic                accepted;
      logic                dropped;
      logic [FILL_W-1:0]   fill;
      logic [WORD_W-1:0]   word;
      logic                pull_valid;
      logic                end_of_stream;
   } fifo_outcome_t;

   // -------------------------------------------------------------------------
   // Shadow FIFO: holds its own copy of queue state and registers, predicts
   // the outcome of each accepted request beat and checks response beats in
   // order against the predictions.
   // -------------------------------------------------------------------------
   class fifo_checker;
      logic [WORD_W-1:0]   shadow_words[DEPTH];
      int unsigned         head_idx;
      int unsigned         tail_idx;
      int unsigned         count;
      bit                  closed;
      logic [POLICY_W-1:0] policy;
      logic [CAP_FIELD_W-1:0] capacity;
      fifo_outcome_t       pending_outcomes[$];
      int unsigned         mismatches;

      function new();
         head_idx   = 0;
         tail_idx   = 0;
         count      = 0;
         closed     = 1'b0;
         policy     = POLICY_BLOCK;
         capacity   = CAP_FIELD_W'(DEPTH);
         mismatches = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] value);
         if (index == CSR_DROP_POLICY) policy = value[POLICY_W-1:0];
         else capacity = value[CAP_FIELD_W-1:0];
      endfunction

      function logic [WORD_W-1:0] take_head();
         logic [WORD_W-1:0] w;
         w        = shadow_words[head_idx];
         head_idx = (head_idx + 1) % DEPTH;
         count    = count - 1;
         return w;
      endfunction

      function void put_tail(logic [WORD_W-1:0] w);
         shadow_words[tail_idx] = w;
         tail_idx = (tail_idx + 1) % DEPTH;
         count    = count + 1;
      endfunction

      // Predict the response to one accepted request beat
      function void apply_request(logic [OPCODE_W-1:0] op, logic [WORD_W-1:0] w);
         fifo_outcome_t r;
         int unsigned   limit;
         r = '{accepted: 1'b0, dropped: 1'b0, fill: '0, word: '0,
               pull_valid: 1'b0, end_of_stream: 1'b0};
         // Capacity zero acts as one, anything above the depth saturates
         limit = (capacity == 0) ? 1 : ((capacity > DEPTH) ? DEPTH : capacity);
         case (op)
            OP_PUSH: begin
               if (closed) begin
                  // refused under every policy
               end else if (count < limit) begin
                  put_tail(w);
                  r.accepted = 1'b1;
               end else if (policy == POLICY_DROP_OLDEST) begin
                  void'(take_head());
                  put_tail(w);
                  r.accepted = 1'b1;
                  r.dropped  = 1'b1;
               end else if (policy == POLICY_DROP_NEWEST) begin
                  r.accepted = 1'b1;
                  r.dropped  = 1'b1;
               end
            end
            OP_PULL: begin
               if (count > 0) begin
                  r.word       = take_head();
                  r.pull_valid = 1'b1;
               end else if (closed) begin
                  r.end_of_stream = 1'b1;
               end
            end
            OP_CLOSE: closed = 1'b1;
            default: ;
         endcase
         r.fill = FILL_W'(count);
         pending_outcomes.insert(pending_outcomes.size(), r);
      endfunction

      task report_mismatch(string field, logic [WORD_W-1:0] got,
                           logic [WORD_W-1:0] want);
         mismatches++;
         $display("[%0t] mismatch on %s: got %0h, want %0h", $time, field, got, want);
      endtask

      task compare_response(logic [RSP_TDATA_W-1:0] tdata,
                            logic [RSP_TUSER_W-1:0] tuser);
         fifo_outcome_t want;
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected response beat", tdata[38:7], '0);
            return;
         end
         want = pending_outcomes[0];
         pending_outcomes.delete(0);
         if (tdata[0] !== want.accepted)
            report_mismatch("accepted", tdata[0], want.accepted);
         if (tdata[1] !== want.dropped)
            report_mismatch("dropped", tdata[1], want.dropped);
         if (tdata[6:2] !== want.fill)
            report_mismatch("fill_level", tdata[6:2], want.fill);
         if (tdata[38:7] !== want.word)
            report_mismatch("pull_data", tdata[38:7], want.word);
         if (tdata[39] !== 1'b0)
            report_mismatch("tdata pad bit", tdata[39], 1'b0);
         if (tuser[0] !== want.pull_valid)
            report_mismatch("pull_valid", tuser[0], want.pull_valid);
         if (tuser[1] !== want.end_of_stream)
            report_mismatch("end_of_stream", tuser[1], want.end_of_stream);
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT signals; every input starts at a known value
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [WORD_W-1:0]      req_tdata  = '0;   // [31:0] push_data
   logic [OPCODE_W-1:0]    req_tuser  = '0;   // [1:0] opcode

   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [0] accepted, [1] dropped, [6:2] fill_level, [38:7] pull_data, [39] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // [0] pull_valid, [1] end_of_stream
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // Idle percentages of the two sides, changed per traffic phase
   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct  = 0;
   int unsigned quiet_cycles  = 0;

   fifo_checker board = new();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bounded_fifo_with_drop_policy_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Stall the response side at random; a zero percentage keeps it ready
   always @(posedge clock)
      rsp_tready <= (rsp_idle_pct == 0) || ($urandom_range(0, 99) >= rsp_idle_pct);

   // Check each response beat as it is taken
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         board.compare_response(rsp_tdata, rsp_tuser);

   // Watchdog: end the run once nothing has moved on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers. Each task is entered at a rising edge and returns at the edge
   // where its last beat was taken, so valid is never lowered and raised in
   // the same step.
   // -------------------------------------------------------------------------

   // Present one request beat, after an optional random gap
   task automatic send_request(input logic [OPCODE_W-1:0] op,
                               input logic [WORD_W-1:0] word);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      board.apply_request(op, word);
   endtask

   // Hold the request side idle until every predicted response has arrived
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending_outcomes.size() != 0);
   endtask

   // Write both registers back to back; call only with the block idle
   task automatic configure(input logic [CSR_DATA_W-1:0] policy_word,
                            input logic [CSR_DATA_W-1:0] cap_word);
      csr_valid <= 1'b1;
      csr_index <= CSR_DROP_POLICY;
      csr_data  <= policy_word;
      do @(posedge clock); while (!csr_ready);
      board.write_register(CSR_DROP_POLICY, policy_word);
      csr_index <= CSR_CAPACITY;
      csr_data  <= cap_word;
      do @(posedge clock); while (!csr_ready);
      board.write_register(CSR_CAPACITY, cap_word);
      csr_valid <= 1'b0;
   endtask

   // Data words lean toward all zeros and all ones now and then
   function automatic logic [WORD_W-1:0] random_word();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return $urandom;
   endfunction

   // Random traffic; push_pct steers the queue toward full or empty
   task automatic run_traffic(input int items, input int push_pct, input bit with_close);
      int                  i;
      int unsigned         pick;
      logic [OPCODE_W-1:0] op;
      for (i = 0; i < items; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < push_pct) op = OP_PUSH;
         else if (pick < 96) op = OP_PULL;
         else if (with_close && pick < 98) op = OP_CLOSE;
         else op = OP_NONE;
         send_request(op, random_word());
         // Now and then let the response side catch up completely
         if ($urandom_range(0, 59) == 0) wait_for_drain();
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      int mode;
      int k;
      int n;
      logic [CSR_DATA_W-1:0] cap_extremes[6];
      logic [CSR_DATA_W-1:0] cap_word;
      logic [POLICY_W-1:0]   policy_code;

      cap_extremes = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed opening under moderate idling on both sides
      send_idle_pct = 31;
      rsp_idle_pct  = 53;

      // Pull on an empty open queue, then the no-op opcode
      send_request(OP_PULL, '1);
      send_request(OP_NONE, '1);
      // Data extremes at the reset settings
      send_request(OP_PUSH, '0);
      send_request(OP_PUSH, '1);
      send_request(OP_PUSH, 32'hA5A5_5A5A);

      // Lower the capacity to the fill level: block refuses
      wait_for_drain();
      configure({3'b000, POLICY_BLOCK}, 5'd3);
      send_request(OP_PUSH, 32'h0000_0001);

      // Capacity zero acts as one: drop oldest evicts, level holds
      wait_for_drain();
      configure({3'b111, POLICY_DROP_OLDEST}, 5'd0);
      send_request(OP_PUSH, 32'h8000_0002);

      // Drop newest: accepted yet dropped
      wait_for_drain();
      configure({3'b101, POLICY_DROP_NEWEST}, 5'd1);
      send_request(OP_PUSH, 32'h7FFF_FFFD);

      // Spare policy code acts as block; capacity above depth saturates
      wait_for_drain();
      configure({3'b010, POLICY_SPARE}, 5'd31);
      send_request(OP_PUSH, 32'h0000_0004);

      // Drain the queue past empty
      repeat (5) send_request(OP_PULL, random_word());

      // Random traffic over three idling patterns and a spread of settings
      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle_pct = 31; rsp_idle_pct = 53; end
            1: begin send_idle_pct = 53; rsp_idle_pct = 31; end
            default: begin send_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         for (k = 0; k < 4; k++) begin
            policy_code = POLICY_W'(k + mode);
            if (k < 2) cap_word = cap_extremes[$urandom_range(0, 5)];
            else cap_word = CSR_DATA_W'($urandom_range(0, 31));
            wait_for_drain();
            configure({3'($urandom_range(0, 7)), policy_code}, cap_word);
            run_traffic(115, $urandom_range(35, 75), 1'b0);
         end
      end

      // Closing phase: fill under drop oldest, then close the queue for good
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      wait_for_drain();
      configure({3'b000, POLICY_DROP_OLDEST}, 5'd4);
      run_traffic(20, 80, 1'b0);
      send_request(OP_CLOSE, random_word());
      send_request(OP_CLOSE, random_word());
      send_request(OP_PUSH, '1);

      // Pushes after close fail even where a drop policy would take them
      wait_for_drain();
      configure({3'b000, POLICY_DROP_NEWEST}, 5'd1);
      send_request(OP_PUSH, '0);
      send_request(OP_NONE, '0);

      // Pull past the last word to reach end of stream
      n = board.count + 2;
      repeat (n) send_request(OP_PULL, random_word());
      run_traffic(30, 40, 1'b1);

      // Let every response arrive, then idle to catch any stray beats
      wait_for_drain();
      repeat (4) @(posedge clock);

      if (board.mismatches == 0 && board.pending_outcomes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/bfdp_pkg.sv
hdl/bfdp_cell.sv
hdl/bounded_fifo_with_drop_policy_core.sv
bench/tb_bounded_fifo_with_drop_policy_core.sv
